/* sv/dbu_pkg.sv */
// shared types and constants for the discrete bayes update block
// used by dbu_ctrl, dbu_dp and discrete_bayes_update; no dependencies
`default_nettype none

package dbu_pkg;

    localparam int ENT_W     = 6;   // entry position width
    localparam int VAL_W     = 16;  // q0.16 probability width
    localparam int CNT_W     = 7;   // entry count register width
    localparam int OP_W      = 2;
    localparam int PROD_W    = 32;  // q0.32 product
    localparam int SUM_W     = 38;  // sum of up to 64 products
    localparam int REM_W     = SUM_W + 1;
    localparam int QUO_W     = VAL_W + 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = 5;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 24;
    localparam int MAX_RUN   = 64;  // entries addressable by the 6-bit index

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_LIK = 2'd0,
        OP_LOAD_PRI = 2'd1,
        OP_ESTIMATE = 2'd2,
        OP_COPY     = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_MUL,
        ST_SUM_ACC,
        ST_EST_RD,
        ST_EST_MUL,
        ST_EST_DIV,
        ST_EST_OUT,
        ST_CPY_RD,
        ST_CPY_WR
    } state_t;

    typedef struct packed {
        logic             load_lik;
        logic             load_pri;
        logic [ENT_W-1:0] ent;
        logic             sum_clr;
        logic             mul;
        logic             acc;
        logic             div_step;
        logic             div_first;
        logic             emit;
        logic             last;
        logic             copy_wr;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic sum_zero;
    } stat_t;

endpackage

`default_nettype wire

/* sv/dbu_ctrl.sv */
// controller for the discrete bayes update block: sequences loads,
// the sum pass, per-entry divide and emit, and the posterior copy
// depends on dbu_pkg
`default_nettype none

module dbu_ctrl #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [dbu_pkg::CNT_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    input  wire dbu_pkg::op_t          in_op,
    output logic                       in_ready,
    output dbu_pkg::cmd_t              cmd,
    input  wire dbu_pkg::stat_t        stat
);
    import dbu_pkg::*;

    localparam int LIM = (MAX_ENTRIES < MAX_RUN) ? MAX_ENTRIES : MAX_RUN;

    state_t             state_reg, state_next;
    logic [ENT_W-1:0]   ent_reg, ent_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   n_act;
    logic               noop;
    logic               is_last;

    // count in use, limited to the store depth and the index range
    assign n_act   = (count_reg > CNT_W'(LIM)) ? CNT_W'(LIM) : count_reg;
    assign noop    = (n_act < CNT_W'(2));
    assign is_last = ((CNT_W'(ent_reg) + CNT_W'(1)) == n_act);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ent_reg   <= '0;
            step_reg  <= '0;
            count_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            ent_reg   <= ent_next;
            step_reg  <= step_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.ent    = ent_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_LOAD_LIK: cmd.load_lik = 1'b1;
                        OP_LOAD_PRI: cmd.load_pri = 1'b1;
                        OP_ESTIMATE:
                        begin
                            if (!noop)
                            begin
                                cmd.sum_clr = 1'b1;
                                ent_next    = '0;
                                state_next  = ST_SUM_RD;
                            end
                        end
                        OP_COPY:
                        begin
                            if (!noop)
                            begin
                                ent_next   = '0;
                                state_next = ST_CPY_RD;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SUM_RD:  state_next = ST_SUM_MUL;
            ST_SUM_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                cmd.acc = 1'b1;
                if (is_last)
                begin
                    ent_next   = '0;
                    state_next = ST_EST_RD;
                end
                else
                begin
                    ent_next   = ent_reg + ENT_W'(1);
                    state_next = ST_SUM_RD;
                end
            end
            ST_EST_RD:  state_next = ST_EST_MUL;
            ST_EST_MUL:
            begin
                cmd.mul    = 1'b1;
                step_next  = '0;
                // a zero sum needs no divide, posteriors are forced to zero
                state_next = stat.sum_zero ? ST_EST_OUT : ST_EST_DIV;
            end
            ST_EST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (step_reg == '0);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_EST_OUT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_EST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = is_last;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ent_next   = ent_reg + ENT_W'(1);
                        state_next = ST_EST_RD;
                    end
                end
            end
            ST_CPY_RD:  state_next = ST_CPY_WR;
            ST_CPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                if (is_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ent_next   = ent_reg + ENT_W'(1);
                    state_next = ST_CPY_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EST_DIV) |-> (step_reg < STEP_W'(DIV_STEPS)))
        else $error("divide step counter out of range");

    a_ent_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (CNT_W'(ent_reg) < n_act))
        else $error("entry counter beyond active count");

    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_wr |-> ($past(state_reg) == ST_CPY_RD))
        else $error("copy write without a preceding read");
`endif

endmodule

`default_nettype wire

/* sv/dbu_dp.sv */
// datapath for the discrete bayes update block: the three stores,
// multiplier, sum accumulator, restoring divider and output register
// depends on dbu_pkg
`default_nettype none

module dbu_dp #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dbu_pkg::cmd_t           cmd,
    output dbu_pkg::stat_t               stat,
    input  wire logic [dbu_pkg::ENT_W-1:0] in_index,
    input  wire logic [dbu_pkg::VAL_W-1:0] in_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [dbu_pkg::OUT_W-1:0]    out_data,   // entry_index, posterior, zero pad
    output logic                         out_last,
    output logic                         out_zero
);
    import dbu_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int XW = ((AW > ENT_W) ? AW : ENT_W) + 1;

    logic [VAL_W-1:0]  lik_mem  [MAX_ENTRIES];
    logic [VAL_W-1:0]  pri_mem  [MAX_ENTRIES];
    logic [VAL_W-1:0]  post_mem [MAX_ENTRIES];

    logic [VAL_W-1:0]  lik_rd_reg, pri_rd_reg, post_rd_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_last_reg;
    logic              out_zero_reg;

    logic [XW-1:0]     ent_x, in_x;
    logic [AW-1:0]     ent_addr, in_addr;
    logic              in_ok;
    logic [REM_W-1:0]  trial, diff, sum_x;
    logic              ge;
    logic [VAL_W-1:0]  post_val;

    assign ent_x    = XW'(cmd.ent);
    assign in_x     = XW'(in_index);
    assign ent_addr = ent_x[AW-1:0];
    assign in_addr  = in_x[AW-1:0];
    assign in_ok    = (in_x < XW'(MAX_ENTRIES));

    // restoring divide of product * 2^16 by the sum, one quotient bit a cycle
    assign sum_x = {1'b0, sum_reg};
    assign trial = cmd.div_first ? REM_W'(prod_reg) : {rem_reg[REM_W-2:0], 1'b0};
    assign ge    = (trial >= sum_x);
    assign diff  = trial - sum_x;

    assign stat.sum_zero = (sum_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    // quotient bit 16 only when the product equals the sum: saturate
    assign post_val = stat.sum_zero ? '0 :
                      (quo_reg[QUO_W-1] ? {VAL_W{1'b1}} : quo_reg[VAL_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_lik && in_ok)
        begin
            lik_mem[in_addr] <= in_value;
        end
        if (cmd.copy_wr)
        begin
            pri_mem[ent_addr] <= post_rd_reg;
        end
        else if (cmd.load_pri && in_ok)
        begin
            pri_mem[in_addr] <= in_value;
        end
        if (cmd.emit)
        begin
            post_mem[ent_addr] <= post_val;
        end
    end

    always_ff @(posedge clk)
    begin
        lik_rd_reg  <= lik_mem[ent_addr];
        pri_rd_reg  <= pri_mem[ent_addr];
        post_rd_reg <= post_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= {16'd0, lik_rd_reg} * {16'd0, pri_rd_reg};
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? diff : trial;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
        if (cmd.emit)
        begin
            out_data_reg <= {{(OUT_W - ENT_W - VAL_W){1'b0}}, post_val, cmd.ent};
            out_last_reg <= cmd.last;
            out_zero_reg <= stat.sum_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sum_clr)
            begin
                sum_reg <= '0;
            end
            else if (cmd.acc)
            begin
                sum_reg <= sum_reg + SUM_W'(prod_reg);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_zero  = out_zero_reg;

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("beat overwritten before it was taken");

    a_rem_below_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.div_step) |-> (rem_reg < sum_x))
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

/* sv/discrete_bayes_update.sv */
// a load is accepted in idle; an estimate over n entries first runs the product sum
// (read, multiply, accumulate per entry), then per entry reads, multiplies, runs the
// 17-step divider (skipped when the sum is zero) and emits; a copy reads and writes
// each entry; estimate and copy are no-ops for fewer than two entries
// reset: control state and output valid clear, entry_count is 1, stores undefined
`default_nettype none

module discrete_bayes_update #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata,      // entry_count
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // op[1:0], index[7:2], value[23:8]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // entry_index[5:0], posterior[21:6], zero
    output logic             m_axis_tlast,
    output logic [0:0]       m_axis_tuser    // sum_zero
);
    import dbu_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    op_t   in_op;
    logic  out_zero;

    assign in_op = op_t'(s_axis_tdata[OP_W-1:0]);

    dbu_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_op     (in_op),
        .in_ready  (s_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    dbu_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_index  (s_axis_tdata[OP_W +: ENT_W]),
        .in_value  (s_axis_tdata[OP_W + ENT_W +: VAL_W]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_zero  (out_zero)
    );

    assign m_axis_tuser = out_zero;

endmodule

`default_nettype wire

/* sim/discrete_bayes_update_check.sv */
// checker for discrete_bayes_update: watches the config port and both streams,
// predicts posterior beats from its own copy of the stores and compares them
// depends on dbu_pkg for op_t and the entry limit
`timescale 1ns / 1ps

module discrete_bayes_update_check #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic [0:0]  m_axis_tuser,
    output int          mismatch_count,
    output int          beats_pending
);
    import dbu_pkg::*;

    localparam int RUN_LIMIT = (MAX_ENTRIES < MAX_RUN) ? MAX_ENTRIES : MAX_RUN;

    typedef struct packed {
        logic [5:0]  entry_index;
        logic [15:0] posterior;
        logic        last;
        logic        sum_zero;
    } posterior_beat_t;

    logic [15:0]     lik_mem  [MAX_RUN];
    logic [15:0]     pri_mem  [MAX_RUN];
    logic [15:0]     post_mem [MAX_RUN];
    logic [6:0]      entry_count;
    logic [37:0]     product_sum;
    posterior_beat_t posterior_q[$];

    task automatic check_beat();
        posterior_beat_t want;
        if (posterior_q.size() == 0)
        begin
            $error("posterior beat with no estimate pending: index %0d, posterior %0d",
                   m_axis_tdata[5:0], m_axis_tdata[21:6]);
            mismatch_count++;
            return;
        end
        want = posterior_q.pop_front();
        if (m_axis_tdata[5:0] !== want.entry_index)
        begin
            $error("entry_index mismatch: expected %0d, got %0d",
                   want.entry_index, m_axis_tdata[5:0]);
            mismatch_count++;
        end
        if (m_axis_tdata[21:6] !== want.posterior)
        begin
            $error("posterior mismatch: expected %0d, got %0d",
                   want.posterior, m_axis_tdata[21:6]);
            mismatch_count++;
        end
        if (m_axis_tlast !== want.last)
        begin
            $error("last mismatch: expected %0d, got %0d", want.last, m_axis_tlast);
            mismatch_count++;
        end
        if (m_axis_tuser[0] !== want.sum_zero)
        begin
            $error("sum_zero mismatch: expected %0d, got %0d",
                   want.sum_zero, m_axis_tuser[0]);
            mismatch_count++;
        end
    endtask

    task automatic apply_item(input logic [23:0] beat);
        op_t             op;
        logic [5:0]      idx;
        logic [15:0]     val;
        int              run;
        logic [37:0]     sum;
        logic [31:0]     prod;
        logic [47:0]     quot;
        posterior_beat_t res;
        op  = op_t'(beat[1:0]);
        idx = beat[7:2];
        val = beat[23:8];
        run = (entry_count > RUN_LIMIT) ? RUN_LIMIT : entry_count;
        case (op)
            OP_LOAD_LIK:
                if (idx < MAX_ENTRIES) lik_mem[idx] = val;
            OP_LOAD_PRI:
                if (idx < MAX_ENTRIES) pri_mem[idx] = val;
            OP_COPY:
                if (entry_count != 7'd1)
                    for (int j = 0; j < run; j++) pri_mem[j] = post_mem[j];
            OP_ESTIMATE:
            begin
                if (entry_count == 7'd1 || run == 0)
                    return;
                sum = '0;
                for (int j = 0; j < run; j++)
                    sum = sum + lik_mem[j] * pri_mem[j];
                product_sum = sum;
                for (int j = 0; j < run; j++)
                begin
                    quot = '0;
                    if (product_sum != 0)
                    begin
                        prod = lik_mem[j] * pri_mem[j];
                        quot = {prod, 16'h0000} / product_sum;
                        // only one product holding the whole sum reaches 1.0
                        if (quot > 48'hFFFF) quot = 48'hFFFF;
                    end
                    post_mem[j]     = quot[15:0];
                    res.entry_index = j;
                    res.posterior   = quot[15:0];
                    res.last        = (j == run - 1);
                    res.sum_zero    = (product_sum == 0);
                    posterior_q.push_back(res);
                end
            end
        endcase
    endtask

    initial
    begin
        mismatch_count = 0;
        beats_pending  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count = 7'd1;
            product_sum = '0;
            posterior_q.delete();
            beats_pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_beat();
            if (cfg_we)
                entry_count = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                apply_item(s_axis_tdata);
            beats_pending = posterior_q.size();
        end
    end

endmodule

/* sim/discrete_bayes_update_test.sv */
// top of the discrete_bayes_update testbench: clock, reset, config writes,
// load/estimate/copy stimulus and the output stall pattern; the verdict comes
// from discrete_bayes_update_check; depends on dbu_pkg and the block's rtl
`timescale 1ns / 1ps

module discrete_bayes_update_test;
    import dbu_pkg::*;

    typedef enum int {
        FILL_RANDOM,
        FILL_SMALL,
        FILL_SPARSE,
        FILL_ZERO
    } fill_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [6:0]  cfg_wdata     = 7'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [23:0] s_axis_tdata  = 24'd0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;
    int          mismatch_count;
    int          beats_pending;

    // entries that hold a written value, so no estimate or copy reads garbage
    logic [63:0] lik_ok  = '0;
    logic [63:0] pri_ok  = '0;
    logic [63:0] post_ok = '0;
    int          run_len = 0;
    bit          tx_calm = 1'b0;
    int          sent    = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    discrete_bayes_update uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    discrete_bayes_update_check check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending)
    );

    initial
    begin
        #12_000_000;
        $display("discrete_bayes_update test failed");
        $finish;
    end

    task automatic send_beat(input op_t op, input logic [5:0] idx, input logic [15:0] val);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, idx, op};
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic load_entry(input op_t op, input logic [5:0] idx, input logic [15:0] val);
        if (op == OP_LOAD_LIK)
            lik_ok[idx] = 1'b1;
        else
            pri_ok[idx] = 1'b1;
        send_beat(op, idx, val);
    endtask

    function automatic bit estimate_ok();
        for (int j = 0; j < run_len; j++)
            if (!lik_ok[j] || !pri_ok[j]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit copy_ok();
        for (int j = 0; j < run_len; j++)
            if (!post_ok[j]) return 1'b0;
        return 1'b1;
    endfunction

    // index and value are don't-care for estimate and copy, so randomize them
    task automatic estimate();
        for (int j = 0; j < run_len; j++) post_ok[j] = 1'b1;
        send_beat(OP_ESTIMATE, $urandom_range(0, 63), $urandom_range(0, 65535));
    endtask

    task automatic copy_posterior();
        for (int j = 0; j < run_len; j++) pri_ok[j] = 1'b1;
        send_beat(OP_COPY, $urandom_range(0, 63), $urandom_range(0, 65535));
    endtask

    // the register may only change once the block has drained
    task automatic set_count(input logic [6:0] count);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (beats_pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we <= 1'b0;
        run_len = (count < 2) ? 0 : ((count > 64) ? 64 : count);
    endtask

    function automatic logic [15:0] draw_value(input fill_t fill);
        if (fill == FILL_SMALL)
            return $urandom_range(0, 15);
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // full load of the distribution in use, then estimate, maybe copy back and re-estimate
    task automatic fill_and_estimate();
        fill_t       fill;
        int          hot;
        logic [15:0] lv;
        fill = fill_t'($urandom_range(0, 3));
        hot  = $urandom_range(0, (run_len > 0) ? run_len - 1 : 0);
        for (int j = 0; j < run_len; j++)
        begin
            lv = draw_value(fill);
            if (fill == FILL_ZERO || (fill == FILL_SPARSE && j != hot))
                lv = 16'h0000;
            load_entry(OP_LOAD_LIK, j, lv);
            load_entry(OP_LOAD_PRI, j,
                       (fill == FILL_SPARSE) ? $urandom_range(1, 65535) : draw_value(fill));
            // stray load outside the active run leaves the result alone
            if (run_len < 64 && $urandom_range(0, 15) == 0)
                load_entry(op_t'($urandom_range(0, 1)), $urandom_range(run_len, 63),
                           $urandom_range(0, 65535));
        end
        estimate();
        if ($urandom_range(0, 1))
        begin
            copy_posterior();
            if ($urandom_range(0, 1))
                estimate();
        end
    endtask

    initial
    begin
        logic [6:0] count;
        op_t        op;
        int         phase;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // count of one after reset: estimate and copy do nothing
        estimate();
        copy_posterior();

        set_count(7'd4);
        load_entry(OP_LOAD_LIK, 0, 16'hFFFF);
        load_entry(OP_LOAD_PRI, 0, 16'hFFFF);
        load_entry(OP_LOAD_LIK, 1, 16'h0000);
        load_entry(OP_LOAD_PRI, 1, 16'h0001);
        load_entry(OP_LOAD_LIK, 2, 16'h0000);
        load_entry(OP_LOAD_PRI, 2, 16'h8000);
        load_entry(OP_LOAD_LIK, 3, 16'h0000);
        load_entry(OP_LOAD_PRI, 3, 16'hFFFF);
        // one product equals the whole sum: saturates
        estimate();
        copy_posterior();
        // all likelihoods zero: sum_zero run
        load_entry(OP_LOAD_LIK, 0, 16'h0000);
        estimate();
        load_entry(OP_LOAD_LIK, 63, 16'hFFFF);
        load_entry(OP_LOAD_PRI, 63, 16'h0000);
        load_entry(OP_LOAD_LIK, 0, 16'h8000);
        load_entry(OP_LOAD_LIK, 1, 16'h5555);
        load_entry(OP_LOAD_LIK, 2, 16'hAAAA);
        load_entry(OP_LOAD_LIK, 3, 16'h0001);
        load_entry(OP_LOAD_PRI, 1, 16'h7FFF);
        load_entry(OP_LOAD_PRI, 2, 16'hFFFF);
        load_entry(OP_LOAD_PRI, 3, 16'h0001);
        estimate();

        // count of zero: also a no-op
        set_count(7'd0);
        estimate();
        copy_posterior();

        phase = 0;
        while (sent < 180 || phase < 1)
        begin
            if (phase == 0)
                count = 7'd127;   // register maximum, limited to 64 entries
            else
                case ($urandom_range(0, 9))
                    0:       count = 7'd0;
                    1:       count = 7'd1;
                    default: count = $urandom_range(2, 10);
                endcase
            set_count(count);
            tx_calm = ($urandom_range(0, 3) == 0);
            repeat ((count == 7'd127) ? 1 : $urandom_range(1, 3))
            begin
                fill_and_estimate();
                repeat ($urandom_range(0, 4))
                begin
                    op = op_t'($urandom_range(0, 3));
                    case (op)
                        OP_LOAD_LIK, OP_LOAD_PRI:
                            load_entry(op, $urandom_range(0, 63), draw_value(FILL_RANDOM));
                        OP_ESTIMATE:
                            if (estimate_ok()) estimate();
                        OP_COPY:
                            if (copy_ok()) copy_posterior();
                    endcase
                end
            end
            phase++;
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (beats_pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (mismatch_count == 0 && beats_pending == 0)
            $display("discrete_bayes_update test passed");
        else
            $display("discrete_bayes_update test failed");
        $finish;
    end

    // output side: random stalls per beat, calm stretches, one long hold-off
    initial
    begin
        int gap;
        int rx_count;
        bit rx_calm;
        bit held;
        rx_count = 0;
        rx_calm  = 1'b0;
        held     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_count == 20 && !held)
            begin
                held = 1'b1;
                repeat (600)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b0;
                end
            end
            if (rx_count % 16 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            gap = rx_calm ? 0 : $urandom_range(0, 8);
            repeat (gap)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            rx_count++;
        end
    end

endmodule
